[rtl/spr_pkg.sv]
// Shared constants, types and helpers for the slotted page row store.
// Used by the top level; no dependencies.
package spr_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int HEADER_BYTES     = 16;
  localparam int SLOT_ENTRY_BYTES = 6;
  localparam int MAX_ROWS         = 64;

  localparam int ADDR_W = $clog2(PAGE_BYTES);
  localparam int POS_W  = $clog2(PAGE_BYTES + 1);
  localparam int SLOT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int DE_W   = POS_W + 4;

  localparam int TYPE_W   = 2;
  localparam int SIDX_W   = 6;
  localparam int LEN_W    = 12;
  localparam int BSIZE_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 2;
  localparam int ROWS_W   = 7;
  localparam int FREE_W   = 13;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_READ    = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_COMPACT = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

  typedef struct packed {
    logic             live;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] len;
  } slot_entry_t;

  // Gap between the end of the slot directory and the lowest row.
  function automatic logic [POS_W-1:0] space_left(logic [POS_W-1:0] rs,
                                                   logic [CNT_W-1:0] tot);
    logic [DE_W-1:0] de;
    logic [DE_W-1:0] rsx;
    de  = DE_W'(HEADER_BYTES) + DE_W'(tot) * DE_W'(SLOT_ENTRY_BYTES);
    rsx = DE_W'(rs);
    return (rsx > de) ? POS_W'(rsx - de) : '0;
  endfunction

endpackage

[rtl/spr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/slotted_page_row_store.sv]
// Slotted page row store: top level with control sequencer and both memories.
// Depends on spr_pkg and spr_ram.
//
// One database page held in a byte RAM (PAGE_BYTES x 8) plus a slot directory
// RAM (MAX_ROWS entries of offset, length, live). Rows are placed downward
// from the page end; the directory grows after the header. Insert bytes are
// taken one per cycle while the input is not stalled: each insert
// transaction is absorbed in the cycle it is accepted, and only the byte
// flagged last_byte returns a result. A read steps through a directory read,
// a byte read and the result, a delete through a directory read and the
// write-back. Compact walks the directory, reading each slot and then
// rewriting its entry, and copies each live row through the byte RAM port
// one byte per cycle (plus a drain step per row), then zeroes everything
// below the packed rows one byte per cycle. The input is stalled while a
// read, delete or compact is in flight, and while a result waits on a
// stalled output.
module slotted_page_row_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spr_pkg::TYPE_W-1:0]   req_type,
  input  logic [spr_pkg::SIDX_W-1:0]   slot_index,
  input  logic [spr_pkg::LEN_W-1:0]    row_length,
  input  logic [spr_pkg::LEN_W-1:0]    byte_offset,
  input  logic [spr_pkg::BSIZE_W-1:0]  buffer_size,
  input  logic [spr_pkg::BYTE_W-1:0]   data_byte,
  input  logic                         last_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spr_pkg::STAT_W-1:0]   status,
  output logic [spr_pkg::SIDX_W-1:0]   assigned_slot,
  output logic [spr_pkg::LEN_W-1:0]    found_length,
  output logic [spr_pkg::BYTE_W-1:0]   read_byte,
  output logic [spr_pkg::ROWS_W-1:0]   rows_in_page,
  output logic [spr_pkg::FREE_W-1:0]   free_bytes
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_DIR, S_RD_BYTE, S_DEL_DIR,
    S_C_RD, S_C_DIR, S_C_COPY, S_C_DRAIN, S_C_ZERO, S_C_DONE
  } state_t;

  state_t state;

  // page state
  logic [spr_pkg::CNT_W-1:0]  slot_total;
  logic [spr_pkg::POS_W-1:0]  rows_start;
  logic                       ins_busy;
  logic                       ins_refused;
  logic [spr_pkg::POS_W-1:0]  ins_pos;
  logic [spr_pkg::POS_W-1:0]  ins_end;

  // latched request
  logic [spr_pkg::SIDX_W-1:0]  q_sidx;
  logic [spr_pkg::LEN_W-1:0]   q_boff;
  logic [spr_pkg::BSIZE_W-1:0] q_bsize;
  logic [spr_pkg::POS_W-1:0]   q_len;

  // compaction walk
  logic [spr_pkg::CNT_W-1:0]   c_idx;
  logic [spr_pkg::CNT_W-1:0]   kept;
  logic [spr_pkg::POS_W-1:0]   top;
  logic [spr_pkg::POS_W-1:0]   cnt;
  logic [spr_pkg::ADDR_W-1:0]  rp;
  logic [spr_pkg::ADDR_W-1:0]  wp;
  logic                        wpend;
  logic [spr_pkg::ADDR_W-1:0]  zp;

  // memory ports
  logic                         row_we;
  logic [spr_pkg::ADDR_W-1:0]   row_waddr;
  logic [spr_pkg::BYTE_W-1:0]   row_wdata;
  logic [spr_pkg::ADDR_W-1:0]   row_raddr;
  logic [spr_pkg::BYTE_W-1:0]   row_rdata;
  logic                         dir_we;
  logic [spr_pkg::SLOT_W-1:0]   dir_waddr;
  spr_pkg::slot_entry_t         dir_wdata;
  logic [spr_pkg::SLOT_W-1:0]   dir_raddr;
  spr_pkg::slot_entry_t         dir_rdata;

  logic out_free;
  logic in_acc;
  logic is_ins;
  logic res_load;

  // insert datapath
  logic                        ins_first;
  logic                        ins_take;
  logic                        refuse_now;
  logic [spr_pkg::POS_W+1:0]   need;
  logic [spr_pkg::POS_W-1:0]   space_now;
  logic [spr_pkg::CNT_W-1:0]   new_total;
  logic [spr_pkg::POS_W-1:0]   new_rs;
  logic [spr_pkg::POS_W-1:0]   pos_use;
  logic [spr_pkg::POS_W-1:0]   end_use;
  logic                        ins_wr;
  logic [spr_pkg::SIDX_W-1:0]  cur_slot;

  // compaction helpers
  logic [spr_pkg::POS_W-1:0]   c_len;
  logic [spr_pkg::POS_W-1:0]   c_dst;

  // read helpers
  logic                        rd_nf;
  logic                        rd_err;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_ins   = (spr_pkg::req_t'(req_type) == spr_pkg::REQ_INSERT);

  spr_ram #(.WIDTH(spr_pkg::BYTE_W), .DEPTH(spr_pkg::PAGE_BYTES)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  spr_ram #(.WIDTH($bits(spr_pkg::slot_entry_t)), .DEPTH(spr_pkg::MAX_ROWS)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  // Insert: first byte reserves the slot when the row fits, every byte writes
  // at the cursor until the row end.
  always_comb begin
    ins_first  = !ins_busy;
    space_now  = spr_pkg::space_left(rows_start, slot_total);
    need       = (spr_pkg::POS_W+2)'(spr_pkg::SLOT_ENTRY_BYTES)
               + (spr_pkg::POS_W+2)'(row_length);
    refuse_now = ins_first
               ? (((spr_pkg::POS_W+2)'(space_now) < need)
                  || (slot_total >= spr_pkg::CNT_W'(spr_pkg::MAX_ROWS)))
               : ins_refused;
    ins_take   = ins_first && !refuse_now;
    new_total  = ins_take ? slot_total + 1'b1 : slot_total;
    new_rs     = ins_take ? rows_start - spr_pkg::POS_W'(row_length) : rows_start;
    pos_use    = ins_take ? new_rs : ins_pos;
    end_use    = ins_take ? rows_start : ins_end;
    ins_wr     = !refuse_now && (pos_use < end_use)
               && (pos_use < spr_pkg::POS_W'(spr_pkg::PAGE_BYTES));
    cur_slot   = spr_pkg::SIDX_W'(new_total - 1'b1);
  end

  always_comb begin
    c_len = (dir_rdata.len > top) ? top : dir_rdata.len;
    c_dst = top - c_len;
    rd_nf  = (spr_pkg::CNT_W'(q_sidx) >= slot_total) || !dir_rdata.live
           || (spr_pkg::SIDX_W'(slot_total) == q_sidx && slot_total == '0);
    rd_err = (spr_pkg::BSIZE_W'(dir_rdata.len) > q_bsize)
           || (spr_pkg::POS_W'(q_boff) >= dir_rdata.len);
  end

  // a result is loaded into the output register this cycle
  always_comb begin
    res_load = 1'b0;
    case (state)
      S_IDLE:                          res_load = in_acc && is_ins && last_byte;
      S_RD_DIR:                        res_load = rd_nf || rd_err;
      S_RD_BYTE, S_DEL_DIR, S_C_DONE:  res_load = 1'b1;
      default: ;
    endcase
  end

  // memory port steering
  always_comb begin
    row_we    = 1'b0;
    row_waddr = wp;
    row_wdata = row_rdata;
    row_raddr = rp;
    dir_we    = 1'b0;
    dir_waddr = spr_pkg::SLOT_W'(slot_total);
    dir_wdata = '{live: 1'b1, off: new_rs, len: spr_pkg::POS_W'(row_length)};
    dir_raddr = spr_pkg::SLOT_W'(slot_index);
    case (state)
      S_IDLE: begin
        if (in_acc && is_ins) begin
          row_we    = ins_wr;
          row_waddr = spr_pkg::ADDR_W'(pos_use);
          row_wdata = data_byte;
          dir_we    = ins_take;
        end
      end
      S_RD_DIR: begin
        row_raddr = spr_pkg::ADDR_W'(dir_rdata.off + spr_pkg::POS_W'(q_boff));
      end
      S_DEL_DIR: begin
        dir_we    = !rd_nf;
        dir_waddr = spr_pkg::SLOT_W'(q_sidx);
        dir_wdata = '{live: 1'b0, off: dir_rdata.off, len: dir_rdata.len};
      end
      S_C_RD: begin
        dir_raddr = spr_pkg::SLOT_W'(c_idx);
      end
      S_C_DIR: begin
        dir_we    = dir_rdata.live;
        dir_waddr = spr_pkg::SLOT_W'(kept);
        dir_wdata = '{live: 1'b1, off: c_dst, len: c_len};
      end
      S_C_COPY, S_C_DRAIN: begin
        row_we = wpend;
      end
      S_C_ZERO: begin
        row_we    = 1'b1;
        row_waddr = zp;
        row_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_total  <= '0;
      rows_start  <= spr_pkg::POS_W'(spr_pkg::PAGE_BYTES);
      ins_busy    <= 1'b0;
      ins_refused <= 1'b0;
      ins_pos     <= '0;
      out_valid   <= 1'b0;
      wpend       <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            q_sidx  <= slot_index;
            q_boff  <= byte_offset;
            q_bsize <= buffer_size;
            if (is_ins) begin
              slot_total  <= new_total;
              rows_start  <= new_rs;
              ins_busy    <= !last_byte;
              ins_refused <= last_byte ? 1'b0 : refuse_now;
              ins_pos     <= ins_wr ? pos_use + 1'b1 : pos_use;
              if (ins_take) begin
                ins_end <= rows_start;
              end
              if (last_byte) begin
                status        <= refuse_now ? spr_pkg::ST_FULL : spr_pkg::ST_OK;
                assigned_slot <= refuse_now ? '0 : cur_slot;
                found_length  <= '0;
                read_byte     <= '0;
                rows_in_page  <= spr_pkg::ROWS_W'(new_total);
                free_bytes    <= spr_pkg::FREE_W'(spr_pkg::space_left(new_rs, new_total));
              end
            end else begin
              ins_busy    <= 1'b0;
              ins_refused <= 1'b0;
              case (spr_pkg::req_t'(req_type))
                spr_pkg::REQ_READ:   state <= S_RD_DIR;
                spr_pkg::REQ_DELETE: state <= S_DEL_DIR;
                default: begin
                  state <= S_C_RD;
                  c_idx <= '0;
                  kept  <= '0;
                  top   <= spr_pkg::POS_W'(spr_pkg::PAGE_BYTES);
                end
              endcase
            end
          end
        end
        S_RD_DIR: begin
          q_len <= dir_rdata.len;
          if (rd_nf || rd_err) begin
            status        <= rd_nf ? spr_pkg::ST_NOT_FOUND : spr_pkg::ST_ERROR;
            assigned_slot <= '0;
            found_length  <= '0;
            read_byte     <= '0;
            rows_in_page  <= spr_pkg::ROWS_W'(slot_total);
            free_bytes    <= spr_pkg::FREE_W'(space_now);
            state         <= S_IDLE;
          end else begin
            state <= S_RD_BYTE;
          end
        end
        S_RD_BYTE: begin
          status        <= spr_pkg::ST_OK;
          assigned_slot <= '0;
          found_length  <= spr_pkg::LEN_W'(q_len);
          read_byte     <= row_rdata;
          rows_in_page  <= spr_pkg::ROWS_W'(slot_total);
          free_bytes    <= spr_pkg::FREE_W'(space_now);
          state         <= S_IDLE;
        end
        S_DEL_DIR: begin
          status        <= rd_nf ? spr_pkg::ST_NOT_FOUND : spr_pkg::ST_OK;
          assigned_slot <= '0;
          found_length  <= '0;
          read_byte     <= '0;
          rows_in_page  <= spr_pkg::ROWS_W'(slot_total);
          free_bytes    <= spr_pkg::FREE_W'(space_now);
          state         <= S_IDLE;
        end
        S_C_RD: begin
          if (c_idx >= slot_total) begin
            slot_total <= kept;
            rows_start <= top;
            zp         <= spr_pkg::ADDR_W'(top - 1'b1);
            state      <= (top == '0) ? S_C_DONE : S_C_ZERO;
          end else begin
            state <= S_C_DIR;
          end
        end
        S_C_DIR: begin
          if (dir_rdata.live) begin
            kept <= kept + 1'b1;
            top  <= c_dst;
          end
          if (!dir_rdata.live || c_len == '0) begin
            c_idx <= c_idx + 1'b1;
            state <= S_C_RD;
          end else begin
            cnt   <= c_len;
            rp    <= spr_pkg::ADDR_W'(dir_rdata.off + c_len - 1'b1);
            wp    <= spr_pkg::ADDR_W'(c_dst + c_len - 1'b1);
            wpend <= 1'b0;
            state <= S_C_COPY;
          end
        end
        S_C_COPY: begin
          // row moves up in place: read descending, each byte written in the cycle after its read
          rp    <= rp - 1'b1;
          cnt   <= cnt - 1'b1;
          wpend <= 1'b1;
          if (wpend) begin
            wp <= wp - 1'b1;
          end
          if (cnt == spr_pkg::POS_W'(1)) begin
            state <= S_C_DRAIN;
          end
        end
        S_C_DRAIN: begin
          wpend <= 1'b0;
          c_idx <= c_idx + 1'b1;
          state <= S_C_RD;
        end
        S_C_ZERO: begin
          zp <= zp - 1'b1;
          if (zp == '0) begin
            state <= S_C_DONE;
          end
        end
        S_C_DONE: begin
          status        <= spr_pkg::ST_OK;
          assigned_slot <= '0;
          found_length  <= '0;
          read_byte     <= '0;
          rows_in_page  <= spr_pkg::ROWS_W'(slot_total);
          free_bytes    <= spr_pkg::FREE_W'(space_now);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
